@@ hdl/hcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// hcpg_pkg: shared types and constants of the Hermite curve point generator
// Field widths, datapath widths, sequencer codes and register indexes.
// ----------------------------------------------------------------------------
package hcpg_pkg;

   localparam int PT_W    = 16;
   localparam int TAN_W   = 16;
   localparam int SEG_W   = 6;
   localparam int COORD_W = 19;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam int CA_W    = 19;
   localparam int CB_W    = 20;
   localparam int CF_W    = 21;
   localparam int ACC_W   = 42;
   localparam int MUL_W   = SEG_W;
   localparam int N2_W    = 2 * SEG_W;
   localparam int N3_W    = 3 * SEG_W;
   localparam int DEN_W   = N3_W + 1;
   localparam int TMP_W   = PT_W + N2_W + 1;
   localparam int BN_W    = CB_W + SEG_W;
   localparam int GNN_W   = TAN_W + N2_W;
   localparam int DN3_W   = PT_W + N3_W + 1;

   localparam int MAG_W   = ACC_W - 1;
   localparam int QB      = 21;
   localparam int HI_W    = MAG_W - QB;
   localparam int MQ_W    = QB + 1;
   localparam int CNT_W   = $clog2(QB);

   localparam int COORD_HI = 2 ** (COORD_W - 1) - 1;
   localparam int COORD_LO_MAG = 2 ** (COORD_W - 1);
   localparam logic [COORD_W-1:0] COORD_MAX_V = COORD_W'(COORD_HI);
   localparam logic [COORD_W-1:0] COORD_MIN_V = {1'b1, {(COORD_W-1){1'b0}}};

   localparam logic [MUL_W-1:0] MUL_TWO = MUL_W'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NPOW,
      ST_COEF,
      ST_EVAL,
      ST_DIVGO,
      ST_DIV,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_FIN
   } div_state_type;

   typedef enum logic [2:0] {
      REG_START_TANGENT_X,
      REG_START_TANGENT_Y,
      REG_END_TANGENT_X,
      REG_END_TANGENT_Y,
      REG_SEGMENTS
   } reg_index_type;

   typedef logic [2:0] step_type;

   localparam step_type NPOW_N2  = 3'd0;
   localparam step_type NPOW_N3  = 3'd1;
   localparam step_type NPOW_DEN = 3'd2;

   localparam step_type COEF_GN  = 3'd0;
   localparam step_type COEF_GNN = 3'd1;
   localparam step_type COEF_DN  = 3'd2;
   localparam step_type COEF_DNN = 3'd3;
   localparam step_type COEF_DN3 = 3'd4;
   localparam step_type COEF_BN  = 3'd5;

   localparam step_type EVAL_A   = 3'd0;
   localparam step_type EVAL_G   = 3'd1;
   localparam step_type EVAL_D   = 3'd2;
   localparam step_type EVAL_RND = 3'd3;

endpackage

@@ hdl/hcpg_mac.sv @@
// ----------------------------------------------------------------------------
// hcpg_mac: shared multiply-add unit
// Forms x * m + y with a signed wide operand and a small unsigned factor.
// ----------------------------------------------------------------------------
module hcpg_mac (
   input  logic signed [hcpg_pkg::ACC_W-1:0] mac_x,
   input  logic        [hcpg_pkg::MUL_W-1:0] mac_m,
   input  logic signed [hcpg_pkg::ACC_W-1:0] mac_y,
   output logic signed [hcpg_pkg::ACC_W-1:0] mac_r
);
   import hcpg_pkg::*;

   logic signed [ACC_W+MUL_W:0] prod;

   always_comb begin
      prod  = mac_x * $signed({1'b0, mac_m});
      mac_r = prod[ACC_W-1:0] + mac_y;
   end

endmodule

@@ hdl/hcpg_div.sv @@
// ----------------------------------------------------------------------------
// hcpg_div: serial floor divider with coordinate saturation
// One quotient bit per cycle; result saturated to the coordinate range.
// ----------------------------------------------------------------------------
module hcpg_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [hcpg_pkg::ACC_W-1:0]   numer,
   input  logic        [hcpg_pkg::DEN_W-1:0]   denom,
   output logic                                done,
   output logic signed [hcpg_pkg::COORD_W-1:0] quot
);
   import hcpg_pkg::*;

   div_state_type state_ff, state_in;
   logic done_ff;
   logic neg_ff, ovf_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QB-1:0] low_ff, quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic signed [COORD_W-1:0] quot_ff, quot_in;
   logic [ACC_W-1:0] mag;
   logic [HI_W-1:0] hi;
   logic ovf;
   logic [DEN_W:0] trial, diff;
   logic ge;
   logic [MQ_W-1:0] mq;

   always_comb begin
      mag    = numer[ACC_W-1] ? (~numer + 1'b1) : numer;
      hi     = mag[MAG_W-1:QB];
      ovf    = hi >= HI_W'(denom);
      trial  = {rem_ff, low_ff[QB-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      mq     = {1'b0, quo_ff} + MQ_W'(rem_ff != '0);
      priority if (ovf_ff) begin
         quot_in = neg_ff ? COORD_MIN_V : COORD_MAX_V;
      end else if (!neg_ff) begin
         quot_in = (quo_ff > QB'(COORD_HI)) ? COORD_MAX_V : quo_ff[COORD_W-1:0];
      end else begin
         quot_in = (mq > MQ_W'(COORD_LO_MAG)) ? COORD_MIN_V
                                              : (~mq[COORD_W-1:0] + 1'b1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) state_in = ovf ? DIV_FIN : DIV_RUN;
         end
         DIV_RUN: begin
            if (cnt_ff == CNT_W'(QB - 1)) state_in = DIV_FIN;
         end
         DIV_FIN: state_in = DIV_IDLE;
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == DIV_FIN);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == DIV_IDLE && start) begin
         neg_ff <= numer[ACC_W-1];
         ovf_ff <= ovf;
         den_ff <= denom;
         rem_ff <= hi[DEN_W-1:0];
         low_ff <= mag[QB-1:0];
         cnt_ff <= '0;
      end else if (state_ff == DIV_RUN) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[QB-2:0], 1'b0};
         quo_ff <= {quo_ff[QB-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == DIV_FIN) quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ hdl/hermite_curve_point_generator.sv @@
// ----------------------------------------------------------------------------
// hermite_curve_point_generator: cubic Hermite curve point generator
// Turns a curve request into segments+1 rounded points along the curve.
// ----------------------------------------------------------------------------
// A request transfer on req_ carries the two endpoints; the tangents and the
// segment count come from the register port (psel/penable, pready always
// high). For n segments the block returns n+1 points on rsp_, t = k/n for
// k = 0..n, with rsp_last_point set on the final one.
// req_stall is low only while no curve is in progress. After a request the
// block forms n^2, n^3 and the scaled coefficients, then for each point:
// per axis four passes of the shared multiply-add (Horner evaluation and
// rounding bias) and the serial divider (launch, 21 quotient steps, finish
// and hand-back), then it hands the point to the output register.
// The output register holds a point while rsp_stall is high; the sequencer
// waits for it before loading the next one, so stalling costs no points.
// Reset empties the output register, returns to idle and restores the
// registers to their defaults.
// ----------------------------------------------------------------------------
module hermite_curve_point_generator #(
   parameter int MAX_SEGMENTS = 63
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_start_x,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_start_y,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_end_x,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_end_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [hcpg_pkg::COORD_W-1:0]  rsp_point_x,
   output logic signed [hcpg_pkg::COORD_W-1:0]  rsp_point_y,
   output logic                                 rsp_last_point,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic        [hcpg_pkg::ADDR_W-1:0]   paddr,
   input  logic        [hcpg_pkg::DATA_W-1:0]   pwdata,
   output logic        [hcpg_pkg::DATA_W-1:0]   prdata,
   output logic                                 pready
);
   import hcpg_pkg::*;

   // register file
   logic signed [TAN_W-1:0] tan0_ff [2];
   logic signed [TAN_W-1:0] tan1_ff [2];
   logic [SEG_W-1:0] seg_ff;
   logic csr_wr;
   reg_index_type csr_idx;

   // sequencer
   seq_state_type state_ff, state_in;
   step_type op_ff, op_in;
   logic axis_ff, axis_in;
   logic [SEG_W-1:0] k_ff, k_in;
   logic req_take, div_start, rsp_load;
   logic rsp_valid_ff;

   // datapath
   logic [SEG_W-1:0] n_ff, n_eff;
   logic [PT_W-1:0] p0_ff [2];
   logic signed [CA_W-1:0] ca_ff [2];
   logic signed [CB_W-1:0] cb_ff [2];
   logic [N2_W-1:0] n2_ff;
   logic [N3_W-1:0] n3_ff;
   logic [DEN_W-1:0] den_ff;
   logic signed [TMP_W-1:0] tmp_ff;
   logic signed [BN_W-1:0] bn_ff [2];
   logic signed [GNN_W-1:0] gnn_ff [2];
   logic signed [DN3_W-1:0] dn3_ff [2];
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic signed [COORD_W-1:0] rsp_point_x_ff, rsp_point_y_ff;
   logic rsp_last_point_ff;

   logic [PT_W-1:0] p0 [2];
   logic [PT_W-1:0] p1 [2];
   logic signed [CF_W-1:0] s0, s1, t0, t1, fa, fb;
   logic signed [CA_W-1:0] ca_in [2];
   logic signed [CB_W-1:0] cb_in [2];

   logic signed [ACC_W-1:0] mac_x, mac_y, mac_r;
   logic [MUL_W-1:0] mac_m;
   logic div_done;
   logic signed [COORD_W-1:0] div_quot;

   // ---------------------------------------------------------------- registers
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_index_type'(paddr[ADDR_W-1:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tan0_ff[0] <= TAN_W'(100);
         tan0_ff[1] <= TAN_W'(-200);
         tan1_ff[0] <= TAN_W'(100);
         tan1_ff[1] <= TAN_W'(200);
         seg_ff     <= SEG_W'(63);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_START_TANGENT_X: tan0_ff[0] <= pwdata[TAN_W-1:0];
            REG_START_TANGENT_Y: tan0_ff[1] <= pwdata[TAN_W-1:0];
            REG_END_TANGENT_X:   tan1_ff[0] <= pwdata[TAN_W-1:0];
            REG_END_TANGENT_Y:   tan1_ff[1] <= pwdata[TAN_W-1:0];
            REG_SEGMENTS:        seg_ff     <= pwdata[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_START_TANGENT_X: prdata = DATA_W'(tan0_ff[0]);
         REG_START_TANGENT_Y: prdata = DATA_W'(tan0_ff[1]);
         REG_END_TANGENT_X:   prdata = DATA_W'(tan1_ff[0]);
         REG_END_TANGENT_Y:   prdata = DATA_W'(tan1_ff[1]);
         REG_SEGMENTS:        prdata = DATA_W'(seg_ff);
         default:             prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ coefficients
   always_comb begin
      p0[0] = req_start_x;
      p0[1] = req_start_y;
      p1[0] = req_end_x;
      p1[1] = req_end_y;
      s0 = '0;
      s1 = '0;
      t0 = '0;
      t1 = '0;
      fa = '0;
      fb = '0;
      for (int i = 0; i < 2; i++) begin
         s0 = $signed(CF_W'(p0[i]));
         s1 = $signed(CF_W'(p1[i]));
         t0 = CF_W'(tan0_ff[i]);
         t1 = CF_W'(tan1_ff[i]);
         fa = (s0 <<< 1) + t0 - (s1 <<< 1) + t1;
         fb = (s1 <<< 1) + s1 - (s0 <<< 1) - s0 - (t0 <<< 1) - t1;
         ca_in[i] = fa[CA_W-1:0];
         cb_in[i] = fb[CB_W-1:0];
      end
   end

   always_comb begin
      priority if (seg_ff == '0) begin
         n_eff = SEG_W'(1);
      end else if (seg_ff > SEG_W'(MAX_SEGMENTS)) begin
         n_eff = SEG_W'(MAX_SEGMENTS);
      end else begin
         n_eff = seg_ff;
      end
   end

   // ---------------------------------------------------------------- sequencer
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      axis_in   = axis_ff;
      k_in      = k_ff;
      req_take  = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_take = 1'b1;
               state_in = ST_NPOW;
               op_in    = NPOW_N2;
               k_in     = '0;
            end
         end
         ST_NPOW: begin
            if (op_ff == NPOW_DEN) begin
               state_in = ST_COEF;
               op_in    = COEF_GN;
               axis_in  = 1'b0;
            end else begin
               op_in = op_ff + 3'd1;
            end
         end
         ST_COEF: begin
            if (op_ff == COEF_BN) begin
               op_in = (axis_ff) ? EVAL_A : COEF_GN;
               if (axis_ff) state_in = ST_EVAL;
               axis_in = !axis_ff;
            end else begin
               op_in = op_ff + 3'd1;
            end
         end
         ST_EVAL: begin
            if (op_ff == EVAL_RND) begin
               state_in = ST_DIVGO;
            end else begin
               op_in = op_ff + 3'd1;
            end
         end
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (axis_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_EVAL;
                  op_in    = EVAL_A;
                  axis_in  = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               if (k_ff == n_ff) begin
                  state_in = ST_IDLE;
                  k_in     = '0;
               end else begin
                  state_in = ST_EVAL;
                  op_in    = EVAL_A;
                  axis_in  = 1'b0;
                  k_in     = k_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         axis_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         axis_ff  <= axis_in;
         k_ff     <= k_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------- shared unit
   always_comb begin
      mac_x = '0;
      mac_m = '0;
      mac_y = '0;
      unique case (state_ff)
         ST_NPOW: begin
            case (op_ff)
               NPOW_N2: begin
                  mac_x = ACC_W'(n_ff);
                  mac_m = n_ff;
               end
               NPOW_N3: begin
                  mac_x = ACC_W'(n2_ff);
                  mac_m = n_ff;
               end
               default: begin
                  mac_x = ACC_W'(n3_ff);
                  mac_m = MUL_TWO;
               end
            endcase
         end
         ST_COEF: begin
            mac_m = n_ff;
            case (op_ff)
               COEF_GN: mac_x = ACC_W'(tan0_ff[axis_ff]);
               COEF_DN: mac_x = ACC_W'(p0_ff[axis_ff]);
               COEF_BN: mac_x = ACC_W'(cb_ff[axis_ff]);
               default: mac_x = ACC_W'(tmp_ff);
            endcase
         end
         ST_EVAL: begin
            case (op_ff)
               EVAL_A: begin
                  mac_x = ACC_W'(ca_ff[axis_ff]);
                  mac_m = k_ff;
                  mac_y = ACC_W'(bn_ff[axis_ff]);
               end
               EVAL_G: begin
                  mac_x = acc_ff;
                  mac_m = k_ff;
                  mac_y = ACC_W'(gnn_ff[axis_ff]);
               end
               EVAL_D: begin
                  mac_x = acc_ff;
                  mac_m = k_ff;
                  mac_y = ACC_W'(dn3_ff[axis_ff]);
               end
               default: begin
                  mac_x = acc_ff;
                  mac_m = MUL_TWO;
                  mac_y = ACC_W'(n3_ff);
               end
            endcase
         end
         default: ;
      endcase
   end

   hcpg_mac u_mac (
      .mac_x (mac_x),
      .mac_m (mac_m),
      .mac_y (mac_y),
      .mac_r (mac_r)
   );

   hcpg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (acc_ff),
      .denom (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_take) begin
         n_ff     <= n_eff;
         p0_ff[0] <= req_start_x;
         p0_ff[1] <= req_start_y;
         ca_ff[0] <= ca_in[0];
         ca_ff[1] <= ca_in[1];
         cb_ff[0] <= cb_in[0];
         cb_ff[1] <= cb_in[1];
      end
      unique case (state_ff)
         ST_NPOW: begin
            case (op_ff)
               NPOW_N2: n2_ff  <= mac_r[N2_W-1:0];
               NPOW_N3: n3_ff  <= mac_r[N3_W-1:0];
               default: den_ff <= mac_r[DEN_W-1:0];
            endcase
         end
         ST_COEF: begin
            case (op_ff)
               COEF_GNN: gnn_ff[axis_ff] <= mac_r[GNN_W-1:0];
               COEF_DN3: dn3_ff[axis_ff] <= mac_r[DN3_W-1:0];
               COEF_BN:  bn_ff[axis_ff]  <= mac_r[BN_W-1:0];
               default:  tmp_ff          <= mac_r[TMP_W-1:0];
            endcase
         end
         ST_EVAL: acc_ff <= mac_r;
         ST_DIV: begin
            if (div_done) begin
               if (axis_ff) begin
                  py_ff <= div_quot;
               end else begin
                  px_ff <= div_quot;
               end
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_point_x_ff    <= px_ff;
         rsp_point_y_ff    <= py_ff;
         rsp_last_point_ff <= (k_ff == n_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_point_x_ff;
   assign rsp_point_y    = rsp_point_y_ff;
   assign rsp_last_point = rsp_last_point_ff;

endmodule

@@ verif/hcpg_point_checker.sv @@
// ----------------------------------------------------------------------------
// hcpg_point_checker: point predictor and comparator for the curve generator
// Tracks register writes on the csr port, expands every accepted curve
// request into its rounded Hermite points and compares each point transfer,
// field by field, with the oldest point still owed.
// ----------------------------------------------------------------------------
module hcpg_point_checker #(
   parameter int MAX_SEGMENTS = 63
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_start_x,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_start_y,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_end_x,
   input  logic        [hcpg_pkg::PT_W-1:0]     req_end_y,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [hcpg_pkg::COORD_W-1:0]  rsp_point_x,
   input  logic signed [hcpg_pkg::COORD_W-1:0]  rsp_point_y,
   input  logic                                 rsp_last_point,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic        [hcpg_pkg::ADDR_W-1:0]   paddr,
   input  logic        [hcpg_pkg::DATA_W-1:0]   pwdata,
   output int                                   failures,
   output int                                   outstanding
);
   import hcpg_pkg::*;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } curve_point_type;

   logic signed [TAN_W-1:0] tan_start_x;
   logic signed [TAN_W-1:0] tan_start_y;
   logic signed [TAN_W-1:0] tan_end_x;
   logic signed [TAN_W-1:0] tan_end_y;
   logic        [SEG_W-1:0] seg_count;

   curve_point_type owed_points[$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      failures++;
   endtask

   // exact value at t = k/n, rounded half up, clamped to the coordinate range
   function automatic logic signed [COORD_W-1:0] hermite_coord(
      input longint a, input longint b, input longint g, input longint d,
      input longint k, input longint n);
      longint n3;
      longint num;
      longint den;
      longint q;
      n3  = n * n * n;
      num = 2 * (a * k * k * k + b * k * k * n + g * k * n * n + d * n3) + n3;
      den = 2 * n3;
      q   = num / den;
      if ((num % den) != 0 && num < 0)
         q = q - 1;
      if (q < -longint'(COORD_LO_MAG))
         q = -longint'(COORD_LO_MAG);
      if (q > longint'(COORD_HI))
         q = longint'(COORD_HI);
      return q[COORD_W-1:0];
   endfunction

   task automatic plot_curve();
      longint x0, y0, x1, y1, tx0, ty0, tx1, ty1, ax, bx, ay, by, n;
      curve_point_type pt;
      x0  = longint'(req_start_x);
      y0  = longint'(req_start_y);
      x1  = longint'(req_end_x);
      y1  = longint'(req_end_y);
      tx0 = longint'(tan_start_x);
      ty0 = longint'(tan_start_y);
      tx1 = longint'(tan_end_x);
      ty1 = longint'(tan_end_y);
      n   = longint'(seg_count);
      if (n < 1)
         n = 1;
      if (n > MAX_SEGMENTS)
         n = MAX_SEGMENTS;
      ax = 2 * x0 + tx0 - 2 * x1 + tx1;
      bx = -3 * x0 - 2 * tx0 + 3 * x1 - tx1;
      ay = 2 * y0 + ty0 - 2 * y1 + ty1;
      by = -3 * y0 - 2 * ty0 + 3 * y1 - ty1;
      for (longint k = 0; k <= n; k++) begin
         pt.x    = hermite_coord(ax, bx, tx0, x0, k, n);
         pt.y    = hermite_coord(ay, by, ty0, y0, k, n);
         pt.last = (k == n);
         owed_points.push_back(pt);
      end
   endtask

   always @(posedge clock) begin
      curve_point_type want;
      if (reset) begin
         tan_start_x = 16'sd100;
         tan_start_y = -16'sd200;
         tan_end_x   = 16'sd100;
         tan_end_y   = 16'sd200;
         seg_count   = SEG_W'(63);
         owed_points.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[ADDR_W-1:2]))
               REG_START_TANGENT_X: tan_start_x = pwdata[TAN_W-1:0];
               REG_START_TANGENT_Y: tan_start_y = pwdata[TAN_W-1:0];
               REG_END_TANGENT_X:   tan_end_x   = pwdata[TAN_W-1:0];
               REG_END_TANGENT_Y:   tan_end_y   = pwdata[TAN_W-1:0];
               REG_SEGMENTS:        seg_count   = pwdata[SEG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            plot_curve();
         if (rsp_valid && !rsp_stall) begin
            if (owed_points.size() == 0) begin
               report_mismatch($sformatf("point transfer (%0d, %0d) with nothing owed",
                                         rsp_point_x, rsp_point_y));
            end else begin
               want = owed_points.pop_front();
               if (rsp_point_x !== want.x)
                  report_mismatch($sformatf("point_x got %0d, want %0d",
                                            rsp_point_x, want.x));
               if (rsp_point_y !== want.y)
                  report_mismatch($sformatf("point_y got %0d, want %0d",
                                            rsp_point_y, want.y));
               if (rsp_last_point !== want.last)
                  report_mismatch($sformatf("last_point got %b, want %b",
                                            rsp_last_point, want.last));
            end
         end
      end
      outstanding = owed_points.size();
   end

endmodule

@@ verif/hermite_curve_point_generator_test.sv @@
// ----------------------------------------------------------------------------
// hermite_curve_point_generator_test: stimulus and verdict for the generator
// Drives curve requests with random gaps, stalls the point channel at random
// and reprograms tangents and segment count between drained phases; the
// point checker beside the block predicts and compares every point.
// ----------------------------------------------------------------------------
module hermite_curve_point_generator_test;
   import hcpg_pkg::*;

   localparam int MAX_SEG       = 63;
   localparam int IDLE_PCT      = 18;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 100;
   localparam int ITEM_GOAL     = 500;
   localparam int CALM_FIRST    = 200;
   localparam int CALM_LAST     = 300;

   localparam logic [2:0] UNMAPPED_FIRST = 3'd5;
   localparam logic [2:0] UNMAPPED_LAST  = 3'd7;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic        [PT_W-1:0]      req_start_x;
   logic        [PT_W-1:0]      req_start_y;
   logic        [PT_W-1:0]      req_end_x;
   logic        [PT_W-1:0]      req_end_y;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [COORD_W-1:0]   rsp_point_x;
   logic signed [COORD_W-1:0]   rsp_point_y;
   logic                        rsp_last_point;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic        [ADDR_W-1:0]    paddr;
   logic        [DATA_W-1:0]    pwdata;
   logic        [DATA_W-1:0]    prdata;
   logic                        pready;

   int failures;
   int outstanding;
   int sent;
   int quiet = 0;
   bit calm  = 1'b0;

   hermite_curve_point_generator #(.MAX_SEGMENTS(MAX_SEG)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_last_point(rsp_last_point),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   hcpg_point_checker #(.MAX_SEGMENTS(MAX_SEG)) points_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_last_point(rsp_last_point),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .failures(failures), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
   endtask

   task automatic bus_idle();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_curve(input logic [PT_W-1:0] sx, input logic [PT_W-1:0] sy,
                             input logic [PT_W-1:0] ex, input logic [PT_W-1:0] ey);
      calm = (sent >= CALM_FIRST && sent < CALM_LAST);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_corners();
      send_curve(16'h0000, 16'h0000, 16'hffff, 16'hffff);
      send_curve(16'hffff, 16'hffff, 16'h0000, 16'h0000);
      send_curve(16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
      send_curve(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
   endtask

   // hold requests until every owed point has been transferred
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0 || req_stall)
         @(negedge clock);
   endtask

   function automatic logic [TAN_W-1:0] pick_tangent();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return TAN_W'($urandom);
      endcase
   endfunction

   initial begin
      int             phase_len;
      int             pick;
      logic [SEG_W-1:0] seg_now;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x   = '0;
      req_end_y   = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      sent        = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults
      send_curve(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_curve(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_corners();
      settle();

      // largest tangents; segment count written as zero through the width mask
      csr_write(REG_START_TANGENT_X, 32'h0000_7fff);
      csr_write(REG_START_TANGENT_Y, 32'h0000_7fff);
      csr_write(REG_END_TANGENT_X, 32'h0000_7fff);
      csr_write(REG_END_TANGENT_Y, 32'h0000_7fff);
      csr_write(REG_SEGMENTS, 32'h0000_0040);
      bus_idle();
      send_corners();
      settle();

      // smallest tangents with high bits set, one segment
      csr_write(REG_START_TANGENT_X, 32'hffff_8000);
      csr_write(REG_START_TANGENT_Y, 32'hffff_8000);
      csr_write(REG_END_TANGENT_X, 32'hffff_8000);
      csr_write(REG_END_TANGENT_Y, 32'hffff_8000);
      csr_write(REG_SEGMENTS, 32'hffff_ffc1);
      bus_idle();
      send_corners();
      settle();

      // mixed tangents, full segment count; unmapped writes must change nothing
      csr_write(REG_START_TANGENT_X, 32'h0000_7fff);
      csr_write(REG_START_TANGENT_Y, 32'h0000_8000);
      csr_write(REG_END_TANGENT_X, 32'h0000_8000);
      csr_write(REG_END_TANGENT_Y, 32'h0000_7fff);
      csr_write(REG_SEGMENTS, 32'h0000_003f);
      csr_write(UNMAPPED_FIRST, 32'hffff_ffff);
      csr_write(UNMAPPED_LAST, 32'h0000_0000);
      bus_idle();
      send_corners();
      settle();
      seg_now = SEG_W'(63);

      while (sent < ITEM_GOAL) begin
         for (int r = REG_START_TANGENT_X; r <= REG_END_TANGENT_Y; r++)
            if ($urandom_range(0, 9) < 6)
               csr_write(3'(r), {16'($urandom), pick_tangent()});
         if ($urandom_range(0, 9) < 7) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
               seg_now = SEG_W'($urandom_range(0, 8));
            else if (pick < 95)
               seg_now = SEG_W'($urandom_range(9, 31));
            else
               seg_now = SEG_W'($urandom_range(32, 63));
            csr_write(REG_SEGMENTS, {26'($urandom), seg_now});
         end
         if ($urandom_range(0, 9) == 0)
            csr_write(3'($urandom_range(UNMAPPED_FIRST, UNMAPPED_LAST)), $urandom);
         bus_idle();
         phase_len = (seg_now > 31) ? 3 : $urandom_range(4, 30);
         repeat (phase_len)
            send_curve(PT_W'($urandom), PT_W'($urandom), PT_W'($urandom), PT_W'($urandom));
         settle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
